// ===== hdl/gain_shape_codebook_search_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the codebook search block.
// ---------------------------------------------------------------------------
`ifndef GAIN_SHAPE_CODEBOOK_SEARCH_MACROS_SVH
`define GAIN_SHAPE_CODEBOOK_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define GSC_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define GSC_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define GSC_ASSERT_IMP(label, clk, rst, a, c)
`define GSC_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== hdl/gscs_pkg.sv =====
// ---------------------------------------------------------------------------
// gscs_pkg
// Shared types and constants of the codebook search.
// ---------------------------------------------------------------------------
package gscs_pkg;
   localparam int ENTRIES_DEF    = 64;
   localparam int VECTOR_LEN_DEF = 16;
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_MATCH = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;
   localparam logic [47:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] ACC_MIN = 48'h8000_0000_0000;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [5:0]  entry;
      logic [3:0]  element;
      logic [11:0] value;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic        kind;
      logic        found;
      logic [5:0]  best_entry;
      logic [26:0] gain;
      logic [47:0] accum_value;
      logic [15:0] hit_count;
   } rsp_type;
endpackage

// ===== hdl/gscs_front.sv =====
// ---------------------------------------------------------------------------
// gscs_front
// Two-entry command queue between the request port and the search engine.
// ---------------------------------------------------------------------------
module gscs_front import gscs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  cmd_type push_data,
   output logic    q_valid,
   input  logic    q_take,
   output cmd_type q_data
);
   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data  = mem_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;

   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wp_ff] <= push_data;
   end
endmodule

// ===== hdl/gscs_sqrt.sv =====
// ---------------------------------------------------------------------------
// gscs_sqrt
// Bit-serial floor(sqrt(floor(num / den))): restoring divide, then root.
// ---------------------------------------------------------------------------
module gscs_sqrt import gscs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [53:0] num,
   input  logic [26:0] den,
   output logic        done,
   output logic [26:0] root
);
   typedef enum logic [1:0] {S_IDLE, S_DIV, S_ROOT, S_DONE} state_type;
   state_type   state_ff;
   logic [53:0] quo_ff;
   logic [27:0] rem_ff;
   logic [26:0] den_ff;
   logic [5:0]  cnt_ff;
   logic [55:0] x_ff;
   logic [26:0] r_ff;
   logic [28:0] rr_ff;
   logic [27:0] rem_sh;
   logic [28:0] trial;
   logic [28:0] rr_sh;

   assign rem_sh = {rem_ff[26:0], quo_ff[53]};
   assign rr_sh  = {rr_ff[26:0], x_ff[55:54]};
   assign trial  = {r_ff, 2'b01};
   assign done   = (state_ff == S_DONE);
   assign root   = r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  quo_ff   <= num;
                  rem_ff   <= '0;
                  den_ff   <= den;
                  cnt_ff   <= 6'd54;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_ff <= rem_sh - {1'b0, den_ff};
                  quo_ff <= {quo_ff[52:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[52:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) state_ff <= S_ROOT;
               x_ff  <= '0;
               r_ff  <= '0;
               rr_ff <= '0;
            end
            S_ROOT: begin
               // first root step loads the quotient
               if (cnt_ff == 6'd0) begin
                  x_ff   <= {2'b00, quo_ff};
                  cnt_ff <= 6'd28;
               end else begin
                  x_ff <= {x_ff[53:0], 2'b00};
                  if (rr_sh >= trial) begin
                     rr_ff <= rr_sh - trial;
                     r_ff  <= {r_ff[25:0], 1'b1};
                  end else begin
                     rr_ff <= rr_sh;
                     r_ff  <= {r_ff[25:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 6'd1;
                  if (cnt_ff == 6'd1) state_ff <= S_DONE;
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hdl/gscs_back.sv =====
// ---------------------------------------------------------------------------
// gscs_back
// Executes queued commands: codebook writes, search walk, statistics.
// ---------------------------------------------------------------------------
module gscs_back import gscs_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int VECTOR_LEN = VECTOR_LEN_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic [6:0] entries_in_use,
   input  logic    q_valid,
   output logic    q_take,
   input  cmd_type q_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);
   localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LW  = $clog2(VECTOR_LEN);
   localparam int AW  = EW + LW;
   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int DEP = ENTRIES * VECTOR_LEN;

   typedef enum logic [4:0] {
      S_IDLE, S_WRD, S_CLR, S_RDA, S_RDB, S_EHEAD, S_DOT, S_DOTW, S_CMP1,
      S_CMPL, S_CMPH, S_CMP2, S_SQRT, S_ACC, S_ACCW, S_MCLR, S_OUT
   } state_type;

   state_type state_ff;
   cmd_type   cmd_ff;

   logic signed [11:0] cw_mem [DEP];
   logic [47:0]        ac_mem [DEP];
   logic [26:0]        en_mem [ENTRIES];
   logic [15:0]        hc_mem [ENTRIES];
   logic [ENTRIES-1:0] cw_vld_ff, ac_vld_ff, en_vld_ff, hc_vld_ff;
   logic signed [11:0] mb_ff [VECTOR_LEN];
   logic [LW-1:0]      mpos_ff;

   logic [AW-1:0]      cw_ra, ac_ra, ac_wa;
   logic [EW-1:0]      hc_ra;
   logic signed [11:0] cw_rd_ff;
   logic [47:0]        ac_rd_ff;
   logic [26:0]        en_rd_ff;
   logic [15:0]        hc_rd_ff;
   logic               cw_rv_ff, ac_rv_ff, en_rv_ff, hc_rv_ff;
   logic signed [11:0] cw_q;
   logic [47:0]        ac_q;
   logic [26:0]        en_q;
   logic [15:0]        hc_q;

   logic [CW-1:0]      n_ff;
   logic [CW-1:0]      k_ff;
   logic [LW:0]        i_ff;
   logic signed [11:0] mb_rd_ff;
   logic signed [23:0] prod_ff;
   logic signed [28:0] dot_ff;
   logic [26:0]        e_ff;
   logic               found_ff;
   logic [EW-1:0]      best_ff;
   logic [27:0]        bd_ff;
   logic [26:0]        be_ff;
   logic [55:0]        bd2_ff, d2_ff;
   logic [54:0]        pl_l_ff, pl_r_ff, ph_l_ff, ph_r_ff;
   logic [82:0]        lhs, rhs;
   logic               sq_start_ff;
   logic               sq_done;
   logic [26:0]        sq_root;
   logic [26:0]        gain_ff;
   logic signed [39:0] gp_ff;
   logic signed [48:0] sum;
   logic [47:0]        sat;
   logic [LW-1:0]      wlo;
   logic               rsp_full_ff;
   logic               rsp_load;
   rsp_type            rsp_ff;
   logic signed [23:0] sq_new, sq_old;
   logic [26:0]        en_upd;
   logic               ent_ok, elem_ok;

   assign q_take    = (state_ff == S_IDLE) && q_valid;
   assign rsp_empty = !rsp_full_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_load  = ((state_ff == S_RDB) || (state_ff == S_OUT)) &&
                      (!rsp_full_ff || rsp_pop);
   assign cw_q      = cw_rv_ff ? cw_rd_ff : 12'sd0;
   assign ac_q      = ac_rv_ff ? ac_rd_ff : 48'd0;
   assign en_q      = en_rv_ff ? en_rd_ff : 27'd0;
   assign hc_q      = hc_rv_ff ? hc_rd_ff : 16'd0;
   assign ent_ok    = ({26'd0, cmd_ff.entry} < 32'(ENTRIES));
   assign elem_ok   = ({28'd0, cmd_ff.element} < 32'(VECTOR_LEN));
   assign wlo       = cmd_ff.element[LW-1:0];
   assign sq_new    = $signed(cmd_ff.value) * $signed(cmd_ff.value);
   assign sq_old    = cw_q * cw_q;
   assign en_upd    = en_q - 27'(sq_old) + 27'(sq_new);
   assign sum       = {ac_q[47], ac_q} + 49'(gp_ff);
   assign sat       = (sum[48] != sum[47]) ? (sum[48] ? ACC_MIN : ACC_MAX) : sum[47:0];

   // exact compare operands: dot^2 * best_energy vs best_dot^2 * energy
   assign lhs = {ph_l_ff, 28'd0} + {28'd0, pl_l_ff};
   assign rhs = {ph_r_ff, 28'd0} + {28'd0, pl_r_ff};

   always_comb begin
      cw_ra = {cmd_ff.entry[EW-1:0], wlo};
      ac_ra = {cmd_ff.entry[EW-1:0], wlo};
      hc_ra = best_ff;
      if (state_ff == S_IDLE) begin
         cw_ra = {q_data.entry[EW-1:0], q_data.element[LW-1:0]};
         hc_ra = q_data.entry[EW-1:0];
      end
      if (state_ff == S_RDA || state_ff == S_RDB) begin
         hc_ra = cmd_ff.entry[EW-1:0];
      end
      if (state_ff == S_EHEAD || state_ff == S_DOT) begin
         cw_ra = {k_ff[EW-1:0], i_ff[LW-1:0]};
      end
      if (state_ff == S_SQRT || state_ff == S_ACC || state_ff == S_ACCW) begin
         ac_ra = {best_ff, i_ff[LW-1:0]};
      end
   end
   assign ac_wa = {best_ff, i_ff[LW-1:0]};

   // memory reads, registered
   always_ff @(posedge clock) begin
      cw_rd_ff <= cw_mem[cw_ra];
      cw_rv_ff <= cw_vld_ff[cw_ra[AW-1:LW]];
      ac_rd_ff <= ac_mem[ac_ra];
      ac_rv_ff <= ac_vld_ff[ac_ra[AW-1:LW]];
      en_rd_ff <= en_mem[(state_ff == S_IDLE) ? q_data.entry[EW-1:0] : k_ff[EW-1:0]];
      en_rv_ff <= en_vld_ff[(state_ff == S_IDLE) ? q_data.entry[EW-1:0] : k_ff[EW-1:0]];
      hc_rd_ff <= hc_mem[hc_ra];
      hc_rv_ff <= hc_vld_ff[hc_ra];
   end

   gscs_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start_ff),
      .num   (bd2_ff[53:0]),
      .den   (be_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rsp_full_ff <= 1'b0;
         sq_start_ff <= 1'b0;
         mpos_ff     <= '0;
         cw_vld_ff   <= '0;
         ac_vld_ff   <= '0;
         en_vld_ff   <= '0;
         hc_vld_ff   <= '0;
      end else begin
         if (rsp_pop && rsp_full_ff && !rsp_load) rsp_full_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff <= q_data;
                  unique case (q_data.cmd)
                     CMD_WRITE: state_ff <= S_WRD;
                     CMD_CLEAR: state_ff <= S_CLR;
                     CMD_READ:  state_ff <= S_RDA;
                     CMD_MATCH: begin
                        mb_ff[mpos_ff] <= $signed(q_data.value);
                        mpos_ff <= (32'(mpos_ff) == VECTOR_LEN - 1) ? '0 : mpos_ff + 1'b1;
                        if (q_data.last) begin
                           n_ff     <= ({25'd0, entries_in_use} > 32'(ENTRIES)) ?
                                       CW'(ENTRIES) : CW'(entries_in_use);
                           k_ff     <= '0;
                           found_ff <= 1'b0;
                           best_ff  <= '0;
                           state_ff <= S_EHEAD;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_WRD: begin
               // old codeword and energy now registered
               if (ent_ok && elem_ok) begin
                  cw_mem[{cmd_ff.entry[EW-1:0], wlo}] <= $signed(cmd_ff.value);
                  en_mem[cmd_ff.entry[EW-1:0]] <= en_upd;
                  if (!cw_vld_ff[cmd_ff.entry[EW-1:0]]) begin
                     // first touch of this row: zero the rest
                     cw_vld_ff[cmd_ff.entry[EW-1:0]] <= 1'b1;
                     i_ff     <= '0;
                     state_ff <= S_MCLR;
                  end else begin
                     state_ff <= S_IDLE;
                  end
                  en_vld_ff[cmd_ff.entry[EW-1:0]] <= 1'b1;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_MCLR: begin
               if (i_ff[LW-1:0] != wlo) cw_mem[{cmd_ff.entry[EW-1:0], i_ff[LW-1:0]}] <= '0;
               i_ff <= i_ff + 1'b1;
               if (32'(i_ff) == VECTOR_LEN - 1) state_ff <= S_IDLE;
            end
            S_CLR: begin
               if (ent_ok) begin
                  ac_vld_ff[cmd_ff.entry[EW-1:0]] <= 1'b0;
                  hc_mem[cmd_ff.entry[EW-1:0]]    <= '0;
                  hc_vld_ff[cmd_ff.entry[EW-1:0]] <= 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_RDA: state_ff <= S_RDB;
            S_RDB: begin
               if (!rsp_full_ff || rsp_pop) begin
                  rsp_ff.kind        <= 1'b1;
                  rsp_ff.found       <= 1'b0;
                  rsp_ff.best_entry  <= cmd_ff.entry;
                  rsp_ff.gain        <= '0;
                  rsp_ff.accum_value <= (ent_ok && elem_ok) ? ac_q : 48'd0;
                  rsp_ff.hit_count   <= ent_ok ? hc_q : 16'd0;
                  rsp_full_ff        <= 1'b1;
                  state_ff           <= S_IDLE;
               end
            end
            S_EHEAD: begin
               if (k_ff >= n_ff) begin
                  state_ff <= found_ff ? S_SQRT : S_OUT;
                  i_ff     <= '0;
                  if (found_ff) begin
                     bd2_ff      <= 56'(bd_ff) * 56'(bd_ff);
                     sq_start_ff <= 1'b0;
                  end
               end else begin
                  i_ff     <= '0;
                  dot_ff   <= '0;
                  state_ff <= S_DOT;
               end
            end
            S_DOT: begin
               // pipeline: read cw(i), multiply, accumulate
               mb_rd_ff <= mb_ff[i_ff[LW-1:0]];
               if (i_ff != '0) prod_ff <= cw_q * mb_rd_ff;
               if (i_ff > 1) dot_ff <= dot_ff + 29'(prod_ff);
               e_ff <= en_q;
               i_ff <= i_ff + 1'b1;
               if (32'(i_ff) == VECTOR_LEN) state_ff <= S_DOTW;
            end
            S_DOTW: begin
               dot_ff   <= dot_ff + 29'(prod_ff);
               state_ff <= S_CMP1;
            end
            S_CMP1: begin
               d2_ff    <= 56'($unsigned(dot_ff[27:0])) * 56'($unsigned(dot_ff[27:0]));
               bd2_ff   <= 56'(bd_ff) * 56'(bd_ff);
               state_ff <= S_CMPL;
            end
            S_CMPL: begin
               // low halves of the squares times the energies
               pl_l_ff  <= d2_ff[27:0] * be_ff;
               pl_r_ff  <= bd2_ff[27:0] * e_ff;
               state_ff <= S_CMPH;
            end
            S_CMPH: begin
               ph_l_ff  <= d2_ff[55:28] * be_ff;
               ph_r_ff  <= bd2_ff[55:28] * e_ff;
               state_ff <= S_CMP2;
            end
            S_CMP2: begin
               if (e_ff != '0 && !dot_ff[28] && dot_ff != '0 &&
                   (!found_ff || lhs > rhs)) begin
                  found_ff <= 1'b1;
                  best_ff  <= k_ff[EW-1:0];
                  bd_ff    <= dot_ff[27:0];
                  be_ff    <= e_ff;
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_EHEAD;
            end
            S_SQRT: begin
               if (i_ff == '0) begin
                  sq_start_ff <= 1'b1;
                  i_ff        <= i_ff + 1'b1;
               end else begin
                  sq_start_ff <= 1'b0;
                  if (sq_done) begin
                     gain_ff  <= sq_root;
                     i_ff     <= '0;
                     state_ff <= S_ACC;
                  end
               end
            end
            S_ACC: begin
               gp_ff    <= $signed({1'b0, gain_ff}) * mb_ff[i_ff[LW-1:0]];
               state_ff <= S_ACCW;
            end
            S_ACCW: begin
               ac_mem[ac_wa] <= ac_rv_ff ? sat : 48'(gp_ff);
               i_ff <= i_ff + 1'b1;
               if (32'(i_ff) == VECTOR_LEN - 1) begin
                  ac_vld_ff[best_ff] <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_ACC;
               end
            end
            S_OUT: begin
               if (!rsp_full_ff || rsp_pop) begin
                  rsp_ff.kind        <= 1'b0;
                  rsp_ff.found       <= found_ff;
                  rsp_ff.best_entry  <= found_ff ? 6'(best_ff) : 6'd0;
                  rsp_ff.gain        <= found_ff ? gain_ff : 27'd0;
                  rsp_ff.accum_value <= '0;
                  rsp_ff.hit_count   <= found_ff ?
                     ((hc_q == 16'hFFFF) ? hc_q : hc_q + 16'd1) : 16'd0;
                  if (found_ff) begin
                     if (hc_q != 16'hFFFF) hc_mem[best_ff] <= hc_q + 16'd1;
                     hc_vld_ff[best_ff] <= 1'b1;
                  end
                  for (int j = 0; j < VECTOR_LEN; j++) mb_ff[j] <= '0;
                  mpos_ff     <= '0;
                  rsp_full_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hdl/gain_shape_codebook_search.sv =====
// ---------------------------------------------------------------------------
// gain_shape_codebook_search
// Normalized-correlation codebook search with per-entry statistics.
// ---------------------------------------------------------------------------
// channel  | ports                                   | handshake
// req      | cmd entry element value last            | push / full
// rsp      | kind found best_entry gain accum hit    | pop / empty
// csr      | entries_in_use                          | valid / ready
// A search walks each entry in use through the shared codeword port, then,
// if an entry won, runs the divide/root and the accumulator update.
// Reset is synchronous; the back end stalls only on a full result register.
module gain_shape_codebook_search import gscs_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int VECTOR_LEN = VECTOR_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_entry,
   input  logic [3:0]  req_element,
   input  logic signed [11:0] req_value,
   input  logic        req_last,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic        rsp_found,
   output logic [5:0]  rsp_best_entry,
   output logic [26:0] rsp_gain,
   output logic signed [47:0] rsp_accum_value,
   output logic [15:0] rsp_hit_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_entries_in_use
);
`include "gain_shape_codebook_search_macros.svh"
   logic [6:0] eiu_ff;
   cmd_type    push_data, q_data;
   logic       q_valid, q_take;
   rsp_type    rsp;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) eiu_ff <= 7'd64;
      else if (csr_valid) eiu_ff <= csr_entries_in_use;
   end

   assign push_data = '{cmd: req_cmd, entry: req_entry, element: req_element,
                        value: req_value, last: req_last};

   gscs_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .push_data(push_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
   );

   gscs_back #(.ENTRIES(ENTRIES), .VECTOR_LEN(VECTOR_LEN)) u_back (
      .clock(clock), .reset(reset), .entries_in_use(eiu_ff),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data(rsp)
   );

   assign rsp_kind        = rsp.kind;
   assign rsp_found       = rsp.found;
   assign rsp_best_entry  = rsp.best_entry;
   assign rsp_gain        = rsp.gain;
   assign rsp_accum_value = rsp.accum_value;
   assign rsp_hit_count   = rsp.hit_count;

   `GSC_ASSERT_IMP(a_take_valid, clock, reset, q_take, q_valid)
   `GSC_ASSERT_IMP(a_match_acc0, clock, reset, !empty && !rsp_kind, rsp_accum_value == 48'd0)
   `GSC_ASSERT_IMP(a_nofound, clock, reset, !empty && !rsp_found, rsp_gain == 27'd0)
endmodule

// ===== dv/gain_shape_codebook_search_tb.sv =====
// ---------------------------------------------------------------------------
// gain_shape_codebook_search_tb
// Drives codeword writes, match vectors, accumulator reads and clears into the
// codebook search, predicts every result in the bench, and checks each popped
// result field by field. Runs several entries_in_use settings, with random
// gaps on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module gain_shape_codebook_search_tb;
   import gscs_pkg::*;

   localparam int NUM_ENT = ENTRIES_DEF;
   localparam int VLEN    = VECTOR_LEN_DEF;
   localparam int SETTLE  = 40;
   localparam longint ACC_HI = 64'sd140737488355327;
   localparam longint ACC_LO = -64'sd140737488355328;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_cmd = CMD_WRITE;
   logic [5:0]  req_entry = '0;
   logic [3:0]  req_element = '0;
   logic signed [11:0] req_value = '0;
   logic        req_last = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_kind;
   logic        rsp_found;
   logic [5:0]  rsp_best_entry;
   logic [26:0] rsp_gain;
   logic signed [47:0] rsp_accum_value;
   logic [15:0] rsp_hit_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_entries_in_use = 7'd64;

   always #2 clock = ~clock;

   gain_shape_codebook_search dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_cmd(req_cmd), .req_entry(req_entry), .req_element(req_element),
      .req_value(req_value), .req_last(req_last),
      .empty(empty), .pop(pop),
      .rsp_kind(rsp_kind), .rsp_found(rsp_found), .rsp_best_entry(rsp_best_entry),
      .rsp_gain(rsp_gain), .rsp_accum_value(rsp_accum_value),
      .rsp_hit_count(rsp_hit_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_entries_in_use(csr_entries_in_use)
   );

   // bench copy of the block state
   logic signed [11:0] codeword [NUM_ENT][VLEN];
   longint unsigned    energy [NUM_ENT];
   longint             accum [NUM_ENT][VLEN];
   int unsigned        hits [NUM_ENT];
   logic signed [11:0] match_vec [VLEN];
   int                 match_pos;
   int unsigned        search_width;

   cmd_type pending_items[$];
   rsp_type expected_rsps[$];
   int errors = 0;
   int n_searches = 0, n_hits = 0, n_reads = 0, n_accepted = 0;
   bit burst_tx = 0, burst_rx = 0;

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r, t;
      r = 0;
      for (int b = 27; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   task automatic run_search();
      rsp_type r;
      int unsigned lim;
      bit found;
      int best;
      longint dot;
      longint unsigned bd, be, g, lhs_sq, rhs_sq;
      logic [127:0] lhs, rhs;
      longint s;
      lim = (search_width > NUM_ENT) ? NUM_ENT : search_width;
      found = 0; best = 0; bd = 0; be = 0; g = 0;
      for (int k = 0; k < lim; k++) begin
         if (energy[k] == 0) continue;
         dot = 0;
         for (int i = 0; i < VLEN; i++)
            dot += longint'(codeword[k][i]) * longint'(match_vec[i]);
         if (dot <= 0) continue;
         // exact compare of dot/sqrt(energy) by cross-multiplying squares
         lhs_sq = longint'(dot) * longint'(dot);
         rhs_sq = bd * bd;
         lhs = 128'(lhs_sq) * 128'(be);
         rhs = 128'(rhs_sq) * 128'(energy[k]);
         if (!found || lhs > rhs) begin
            found = 1; best = k; bd = dot; be = energy[k];
         end
      end
      r = '0;
      r.kind = 1'b0;
      if (found) begin
         g = floor_sqrt((bd * bd) / be);
         if (hits[best] < 16'hFFFF) hits[best]++;
         for (int i = 0; i < VLEN; i++) begin
            s = accum[best][i] + longint'(g) * longint'(match_vec[i]);
            if (s > ACC_HI) s = ACC_HI;
            if (s < ACC_LO) s = ACC_LO;
            accum[best][i] = s;
         end
         r.found = 1'b1;
         r.best_entry = best[5:0];
         r.gain = g[26:0];
         r.hit_count = hits[best][15:0];
         n_hits++;
      end
      for (int i = 0; i < VLEN; i++) match_vec[i] = '0;
      match_pos = 0;
      n_searches++;
      expected_rsps.push_back(r);
   endtask

   task automatic predict_item(cmd_type c);
      rsp_type r;
      logic signed [11:0] old;
      case (c.cmd)
         CMD_WRITE: begin
            old = codeword[c.entry][c.element];
            energy[c.entry] = energy[c.entry] - longint'(old) * longint'(old)
                              + longint'($signed(c.value)) * longint'($signed(c.value));
            codeword[c.entry][c.element] = c.value;
         end
         CMD_CLEAR: begin
            for (int i = 0; i < VLEN; i++) accum[c.entry][i] = 0;
            hits[c.entry] = 0;
         end
         CMD_READ: begin
            r = '0;
            r.kind = 1'b1;
            r.best_entry = c.entry;
            r.accum_value = accum[c.entry][c.element][47:0];
            r.hit_count = hits[c.entry][15:0];
            n_reads++;
            expected_rsps.push_back(r);
         end
         default: begin
            match_vec[match_pos] = c.value;
            match_pos = (match_pos + 1) % VLEN;
            if (c.last) run_search();
         end
      endcase
   endtask

   task automatic report_mismatch(string what, longint exp_v, longint got_v);
      $display("MISMATCH %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
      errors++;
   endtask

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 14);
   endfunction

   // sender
   int tx_wait = 0;
   always @(posedge clock) begin
      cmd_type c;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            c.cmd = req_cmd; c.entry = req_entry; c.element = req_element;
            c.value = req_value; c.last = req_last;
            predict_item(c);
            n_accepted++;
            void'(pending_items.pop_front());
         end
         if (!push || !full) begin
            if (tx_wait > 0) begin
               tx_wait--;
               push <= 1'b0;
            end else if (pending_items.size() > 0) begin
               c = pending_items[0];
               push <= 1'b1;
               req_cmd <= c.cmd; req_entry <= c.entry; req_element <= c.element;
               req_value <= c.value; req_last <= c.last;
               if ($urandom_range(0, 63) == 0) burst_tx = ~burst_tx;
               tx_wait = draw_wait(burst_tx);
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // receiver
   int rx_wait = 0;
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("results outstanding", 0, 1);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_kind !== e.kind) report_mismatch("kind", e.kind, rsp_kind);
               if (rsp_found !== e.found) report_mismatch("found", e.found, rsp_found);
               if (rsp_best_entry !== e.best_entry)
                  report_mismatch("best_entry", e.best_entry, rsp_best_entry);
               if (rsp_gain !== e.gain) report_mismatch("gain", e.gain, rsp_gain);
               if (rsp_accum_value !== e.accum_value)
                  report_mismatch("accum_value", $signed(e.accum_value), rsp_accum_value);
               if (rsp_hit_count !== e.hit_count)
                  report_mismatch("hit_count", e.hit_count, rsp_hit_count);
            end
            if ($urandom_range(0, 63) == 0) burst_rx = ~burst_rx;
            rx_wait = draw_wait(burst_rx);
         end
         if (rx_wait > 0) begin
            rx_wait--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   function automatic cmd_type make_item(logic [1:0] cmd, int ent, int el, int val, bit lst);
      cmd_type c;
      c.cmd = cmd; c.entry = ent[5:0]; c.element = el[3:0];
      c.value = val[11:0]; c.last = lst;
      return c;
   endfunction

   function automatic int rand_value();
      case ($urandom_range(0, 9))
         0: return -2048;
         1: return 2047;
         2: return 0;
         default: return int'($signed(12'($urandom)));
      endcase
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_items.size() != 0 || push || expected_rsps.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_width(logic [6:0] w);
      csr_valid <= 1'b1;
      csr_entries_in_use <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      search_width = w;
   endtask

   task automatic fill_random(int count, int unsigned w);
      int made, len, top;
      made = 0;
      top = (w == 0) ? 0 : ((w > NUM_ENT) ? NUM_ENT - 1 : w - 1);
      while (made < count) begin
         case ($urandom_range(0, 99)) inside
            [0:29]: begin
               pending_items.push_back(make_item(CMD_WRITE,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                              : $urandom_range(0, top),
                  $urandom_range(0, 15), rand_value(), 1'($urandom_range(0, 1))));
               made++;
            end
            [30:74]: begin
               len = ($urandom_range(0, 9) < 8) ? VLEN : $urandom_range(1, 24);
               for (int i = 0; i < len; i++)
                  pending_items.push_back(make_item(CMD_MATCH, $urandom_range(0, 63),
                     $urandom_range(0, 15), rand_value(), i == len - 1));
               made += len;
            end
            [75:89]: begin
               pending_items.push_back(make_item(CMD_READ, $urandom_range(0, top),
                  $urandom_range(0, 15), rand_value(), 1'($urandom_range(0, 1))));
               made++;
            end
            [90:94]: begin
               pending_items.push_back(make_item(CMD_CLEAR, $urandom_range(0, top),
                  $urandom_range(0, 15), rand_value(), 1'($urandom_range(0, 1))));
               made++;
            end
            default: begin
               pending_items.push_back(make_item(2'($urandom_range(0, 3)),
                  $urandom_range(0, 63), $urandom_range(0, 15),
                  int'($signed(12'($urandom))), 1'($urandom_range(0, 1))));
               made++;
            end
         endcase
      end
   endtask

   initial begin
      logic [6:0] widths [6];
      widths = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd13, 7'd64};
      for (int k = 0; k < NUM_ENT; k++) begin
         energy[k] = 0; hits[k] = 0;
         for (int i = 0; i < VLEN; i++) begin
            codeword[k][i] = '0; accum[k][i] = 0;
         end
      end
      for (int i = 0; i < VLEN; i++) match_vec[i] = '0;
      match_pos = 0;
      search_width = 64;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme codewords, an overwrite, a negative-dot entry
      pending_items.push_back(make_item(CMD_WRITE, 0, 0, 2047, 0));
      pending_items.push_back(make_item(CMD_WRITE, 0, 15, -2048, 1));
      pending_items.push_back(make_item(CMD_WRITE, 1, 0, -2048, 0));
      pending_items.push_back(make_item(CMD_WRITE, 2, 1, 100, 0));
      pending_items.push_back(make_item(CMD_WRITE, 2, 1, 2047, 0));
      // first vector fills every position before the first search
      for (int i = 0; i < VLEN; i++)
         pending_items.push_back(make_item(CMD_MATCH, 63, i,
            (i == 0) ? 2047 : ((i == 15) ? -2048 : ((i == 1) ? 2047 : 0)),
            i == VLEN - 1));
      pending_items.push_back(make_item(CMD_READ, 0, 0, 0, 0));
      pending_items.push_back(make_item(CMD_CLEAR, 0, 0, 0, 0));
      pending_items.push_back(make_item(CMD_READ, 0, 15, 0, 1));
      // short all-zero vector: no entry can win
      pending_items.push_back(make_item(CMD_MATCH, 0, 0, 0, 1));
      wait_idle();

      foreach (widths[p]) begin
         write_width(widths[p]);
         fill_random(200, widths[p]);
         wait_idle();
      end

      $display("covered %0d items, %0d searches (%0d with a winner), %0d reads",
               n_accepted, n_searches, n_hits, n_reads);
      $display("entries_in_use settings 0, 1, 13, 64 and 127");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("simulation failed");
      $finish;
   end
endmodule
